### src/trs_pkg.sv
// Package for the trail ribbon smoother: shared constants, the spline
// control bundle and the sequencer state type. No dependencies.
`default_nettype none
package trs_pkg;

  localparam int unsigned SEGMENTS_DEF = 32;
  localparam int unsigned T_ONE        = 65536;
  localparam int unsigned CURVE_T_RST  = 32768;
  localparam int unsigned HW           = 40;
  localparam int unsigned NLANE        = 3;
  localparam int unsigned MW           = HW + 18;

  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  typedef enum logic [1:0] {
    SPL_HOLD,
    SPL_COEF,
    SPL_MUL,
    SPL_ACC
  } spl_op_e;

  typedef enum logic [1:0] {
    ADD_B,
    ADD_C,
    ADD_P
  } spl_add_e;

  typedef struct packed {
    logic     ld_en;
    logic [1:0] ld_sel;
    spl_op_e  op;
    spl_add_e add;
  } spl_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_SH_RD,
    ST_SH_WR,
    ST_APP_LO,
    ST_APP_HI,
    ST_SMOOTH,
    ST_EM_RD,
    ST_EM_LD,
    ST_EM_WAIT
  } trs_state_e;

endpackage
`default_nettype wire

### src/trs_store.sv
// One coordinate store of the vertex window: one write port, one
// registered read port. No dependencies.
`default_nettype none
module trs_store #(
  parameter int unsigned DEPTH = 34,
  parameter int unsigned AW    = 6
) (
  input  wire  logic                clk_i,
  input  wire  logic                we_i,
  input  wire  logic [AW-1:0]       waddr_i,
  input  wire  logic signed [31:0]  wdata_i,
  input  wire  logic [AW-1:0]       raddr_i,
  output logic signed [31:0]        rdata_o
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### src/trs_div.sv
// Restoring divider for the texture step: 2^17 over the span, one
// quotient bit per cycle. Depends on nothing.
`default_nettype none
module trs_div #(
  parameter int unsigned DW = 6
) (
  input  wire  logic          clk_i,
  input  wire  logic          rst_ni,
  input  wire  logic          start_i,
  input  wire  logic [DW-1:0] den_i,
  output logic [17:0]         q_o,
  output logic [DW:0]         r_o
);

  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [DW:0] rem_q, rem_d;
  logic [17:0] quo_q, quo_d;
  logic [DW:0] shifted;

  always_comb begin
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    shifted = {rem_q[DW-1:0], (cnt_q == 5'd17)};
    if (start_i) begin
      cnt_d  = 5'd17;
      busy_d = 1'b1;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_i}) begin
        rem_d = shifted - {1'b0, den_i};
        quo_d = {quo_q[16:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[16:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign q_o = quo_q;
  assign r_o = rem_q;

endmodule
`default_nettype wire

### src/trs_spline.sv
// Catmull-Rom evaluation lane: control point registers, one multiplier
// reused for the three Horner steps. Depends on trs_pkg.
`default_nettype none
module trs_spline
  import trs_pkg::*;
(
  input  wire  logic               clk_i,
  input  wire  spl_ctrl_t          ctrl_i,
  input  wire  logic [16:0]        t_i,
  input  wire  logic signed [31:0] rd_i,
  output logic signed [31:0]       res_o
);

  logic signed [31:0]   p_q [4];
  logic signed [HW-1:0] h_q, h_d;
  logic signed [MW-1:0] m_q, m_d;
  logic signed [HW-1:0] e0, e1, e2, e3;
  logic signed [HW-1:0] coef_a, addend, rnd, half;
  logic signed [17:0]   ts;

  always_comb begin
    e0     = HW'(p_q[0]);
    e1     = HW'(p_q[1]);
    e2     = HW'(p_q[2]);
    e3     = HW'(p_q[3]);
    ts     = $signed({1'b0, t_i});
    coef_a = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
    case (ctrl_i.add)
      ADD_B:   addend = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      ADD_C:   addend = e2 - e0;
      ADD_P:   addend = e1 <<< 1;
      default: addend = '0;
    endcase
    rnd = HW'((m_q + MW'(32768)) >>> 16);
    m_d = h_q * ts;
    h_d = h_q;
    case (ctrl_i.op)
      SPL_COEF: h_d = coef_a;
      SPL_ACC:  h_d = rnd + addend;
      default:  h_d = h_q;
    endcase
    half = (h_q + HW'(1)) >>> 1;
    if (half > HW'(32'sh7FFFFFFF)) begin
      res_o = 32'sh7FFFFFFF;
    end else if (half < HW'(-33'sh80000000)) begin
      res_o = 32'sh80000000;
    end else begin
      res_o = half[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_en) begin
      p_q[ctrl_i.ld_sel] <= rd_i;
    end
    h_q <= h_d;
    if (ctrl_i.op == SPL_MUL) begin
      m_q <= m_d;
    end
  end

endmodule
`default_nettype wire

### src/trail_ribbon_smoother.sv
// Top level of the trail ribbon smoother: sequencer, window stores,
// spline lanes and texture divider. Depends on trs_pkg and all submodules.
//
// A start transfer with a valid sample fills all SEGMENTS+2 slots, one slot
// per cycle; otherwise it only empties the window. An update transfer first
// drops the oldest pair when the window is full, then appends the new pair,
// smooths each vertex (four reads from the single read port of each store,
// then three passes through the lane multiplier) and emits each vertex,
// holding while the output stalls. The x, y and z lanes run side by side.
// Input is not taken until the last vertex of the run has been transferred.
`default_nettype none
module trail_ribbon_smoother
  import trs_pkg::*;
#(
  parameter int unsigned SEGMENTS = SEGMENTS_DEF
) (
  input  wire  logic         clk_i,
  input  wire  logic         rst_ni,
  input  wire  logic         cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire  logic [16:0]  cfg_data_i,     // curve_t
  input  wire  logic         s_axis_tvalid,
  output logic               s_axis_tready,
  // low_x, low_y, low_z, high_x, high_y, high_z
  input  wire  logic [191:0] s_axis_tdata,
  // req_type, sample_valid
  input  wire  logic [1:0]   s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire  logic         m_axis_tready,
  // vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v
  output logic [119:0]       m_axis_tdata,
  output logic               m_axis_tlast
);

  localparam int unsigned SLOTS = SEGMENTS + 2;
  localparam int unsigned AW    = $clog2(SLOTS);
  localparam int unsigned CW    = $clog2(SLOTS + 1);

  trs_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] j_q, j_d;
  logic [3:0]    st_q, st_d;
  logic [16:0]   curve_q;
  logic          smp_q, smp_d;
  logic signed [31:0] lo_q [NLANE];
  logic signed [31:0] hi_q [NLANE];
  logic [17:0]   u_q, u_d;
  logic [CW:0]   ur_q, ur_d;
  logic [CW:0]   ur_sum;
  logic          last_q, last_d;
  logic [119:0]  odata_q, odata_d;

  logic [CW-1:0] den;
  logic [16:0]   t_eff;
  logic          s_fire, m_fire, div_start;
  logic [17:0]   div_q;
  logic [CW:0]   div_r;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [1:0]    wsrc;
  spl_ctrl_t     sctrl;
  logic signed [31:0] rd   [NLANE];
  logic signed [31:0] res  [NLANE];
  logic signed [31:0] wdat [NLANE];
  logic signed [CW+1:0] vi;

  function automatic logic [AW-1:0] clampi(logic signed [CW+1:0] v, logic [CW-1:0] n);
    logic signed [CW+1:0] top;
    top = $signed({2'b00, n}) - (CW+2)'(1);
    if (v < 0) begin
      return '0;
    end
    if (v > top) begin
      return top[AW-1:0];
    end
    return v[AW-1:0];
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == ST_EM_WAIT);
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = last_q;
  assign den           = cnt_q - CW'(2);
  assign t_eff         = (curve_q > 17'(T_ONE)) ? 17'(T_ONE) : curve_q;
  assign vi            = $signed({2'b00, j_q});
  assign ur_sum        = ur_q + div_r;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    j_d     = j_q;
    st_d    = st_q;
    smp_d   = smp_q;
    u_d     = u_q;
    ur_d    = ur_q;
    last_d  = last_q;
    odata_d = odata_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          smp_d = s_axis_tuser[1];
          j_d   = '0;
          if (s_axis_tuser[0] == REQ_START) begin
            cnt_d = '0;
            if (s_axis_tuser[1]) begin
              state_d = ST_FILL;
            end
          end else if ((CW+1)'(cnt_q) + (CW+1)'(2) > (CW+1)'(SLOTS)) begin
            cnt_d   = cnt_q - CW'(2);
            state_d = ST_SH_RD;
          end else begin
            state_d = ST_APP_LO;
          end
        end
      end
      ST_FILL: begin
        j_d = j_q + CW'(1);
        if (j_q == CW'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_SH_RD: state_d = ST_SH_WR;
      ST_SH_WR: begin
        j_d = j_q + CW'(1);
        state_d = (j_q + CW'(1) == cnt_q) ? ST_APP_LO : ST_SH_RD;
      end
      ST_APP_LO: state_d = ST_APP_HI;
      ST_APP_HI: begin
        cnt_d   = cnt_q + CW'(2);
        j_d     = '0;
        st_d    = '0;
        state_d = ST_SMOOTH;
      end
      ST_SMOOTH: begin
        st_d = st_q + 4'd1;
        if (st_q == 4'd12) begin
          st_d = '0;
          j_d  = j_q + CW'(1);
          if (j_q + CW'(1) == cnt_q) begin
            j_d     = '0;
            u_d     = '0;
            ur_d    = (CW+1)'(den >> 1);
            state_d = ST_EM_RD;
          end
        end
      end
      ST_EM_RD: state_d = ST_EM_LD;
      ST_EM_LD: begin
        last_d  = (j_q + CW'(1) == cnt_q);
        odata_d = {~j_q[0], u_q[16:0], rd[2], rd[1], rd[0], 6'(j_q)};
        state_d = ST_EM_WAIT;
      end
      ST_EM_WAIT: begin
        if (m_fire) begin
          if (j_q[0]) begin
            if (ur_sum >= (CW+1)'(den)) begin
              u_d  = u_q + div_q + 18'd1;
              ur_d = ur_sum - (CW+1)'(den);
            end else begin
              u_d  = u_q + div_q;
              ur_d = ur_sum;
            end
          end
          j_d     = j_q + CW'(1);
          state_d = last_q ? ST_IDLE : ST_EM_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    we        = 1'b0;
    waddr     = j_q[AW-1:0];
    raddr     = j_q[AW-1:0];
    wsrc      = 2'd0;
    div_start = 1'b0;
    sctrl     = '{ld_en: 1'b0, ld_sel: 2'd0, op: SPL_HOLD, add: ADD_B};
    case (state_q)
      ST_FILL: begin
        we   = !(j_q[0] == 1'b0 && j_q == CW'(SLOTS - 1));
        wsrc = j_q[0] ? 2'd1 : 2'd0;
      end
      ST_SH_RD: raddr = AW'(j_q + CW'(2));
      ST_SH_WR: begin
        we   = 1'b1;
        wsrc = 2'd2;
      end
      ST_APP_LO: begin
        we    = smp_q;
        waddr = cnt_q[AW-1:0];
      end
      ST_APP_HI: begin
        we        = smp_q;
        waddr     = AW'(cnt_q + CW'(1));
        wsrc      = 2'd1;
        div_start = 1'b1;
      end
      ST_SMOOTH: begin
        case (st_q)
          4'd0:    raddr = clampi(vi - (CW+2)'(2), cnt_q);
          4'd1:    raddr = clampi(vi, cnt_q);
          4'd2:    raddr = clampi(vi + (CW+2)'(2), cnt_q);
          4'd3:    raddr = clampi(vi + (CW+2)'(4), cnt_q);
          default: raddr = j_q[AW-1:0];
        endcase
        case (st_q)
          4'd1, 4'd2, 4'd3, 4'd4: begin
            sctrl.ld_en  = 1'b1;
            sctrl.ld_sel = 2'(st_q - 4'd1);
          end
          4'd5:             sctrl.op = SPL_COEF;
          4'd6, 4'd8, 4'd10: sctrl.op = SPL_MUL;
          4'd7: begin
            sctrl.op  = SPL_ACC;
            sctrl.add = ADD_B;
          end
          4'd9: begin
            sctrl.op  = SPL_ACC;
            sctrl.add = ADD_C;
          end
          4'd11: begin
            sctrl.op  = SPL_ACC;
            sctrl.add = ADD_P;
          end
          4'd12: begin
            we   = 1'b1;
            wsrc = 2'd3;
          end
          default: sctrl.op = SPL_HOLD;
        endcase
      end
      default: we = 1'b0;
    endcase
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    always_comb begin
      case (wsrc)
        2'd0:    wdat[l] = lo_q[l];
        2'd1:    wdat[l] = hi_q[l];
        2'd2:    wdat[l] = rd[l];
        default: wdat[l] = res[l];
      endcase
    end

    trs_store #(
      .DEPTH (SLOTS),
      .AW    (AW)
    ) u_store (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdat[l]),
      .raddr_i (raddr),
      .rdata_o (rd[l])
    );

    trs_spline u_spline (
      .clk_i  (clk_i),
      .ctrl_i (sctrl),
      .t_i    (t_eff),
      .rd_i   (rd[l]),
      .res_o  (res[l])
    );
  end

  trs_div #(
    .DW (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .den_i   (den),
    .q_o     (div_q),
    .r_o     (div_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      j_q     <= '0;
      st_q    <= '0;
      curve_q <= 17'(CURVE_T_RST);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      j_q     <= j_d;
      st_q    <= st_d;
      if (cfg_valid_i && cfg_ready_o) begin
        curve_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q   <= smp_d;
    u_q     <= u_d;
    ur_q    <= ur_d;
    last_q  <= last_d;
    odata_q <= odata_d;
    if (s_fire) begin
      for (int l = 0; l < NLANE; l++) begin
        lo_q[l] <= s_axis_tdata[32*l +: 32];
        hi_q[l] <= s_axis_tdata[96 + 32*l +: 32];
      end
    end
  end

endmodule
`default_nettype wire
